### hw/rtl/aecp_pkg.sv
// ----------------------------------------------------------------------------
// aecp_pkg
// Shared types, byte codes and defaults for the terminal escape parser.
// ----------------------------------------------------------------------------
package aecp_pkg;

  // Defaults for top-level parameters
  localparam int ROWS_DEF        = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Screen geometry: COLUMNS feeds a compare, TAB_WIDTH the tab-stop arithmetic
  localparam int COLUMNS   = 80;
  localparam int TAB_WIDTH = 8;

  // Byte codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CUP   = 8'h48;  // H
  localparam logic [7:0] CH_UP    = 8'h41;  // A
  localparam logic [7:0] CH_DOWN  = 8'h42;  // B
  localparam logic [7:0] CH_RIGHT = 8'h43;  // C
  localparam logic [7:0] CH_LEFT  = 8'h44;  // D
  localparam logic [7:0] CH_ED    = 8'h4A;  // J
  localparam logic [7:0] CH_EL    = 8'h4B;  // K
  localparam logic [7:0] CH_IL    = 8'h4C;  // L
  localparam logic [7:0] CH_DL    = 8'h4D;  // M
  localparam logic [7:0] CH_ICH   = 8'h40;  // @
  localparam logic [7:0] CH_DCH   = 8'h50;  // P
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_NBSP  = 8'hA0;

  // Display commands
  typedef enum logic [3:0] {
    CMD_NONE         = 4'd0,
    CMD_PLOT         = 4'd1,
    CMD_SCROLL       = 4'd2,
    CMD_BELL         = 4'd3,
    CMD_ERASE_SCREEN = 4'd4,
    CMD_ERASE_EOL    = 4'd5,
    CMD_INS_LINE     = 4'd6,
    CMD_DEL_LINE     = 4'd7,
    CMD_INS_CHARS    = 4'd8,
    CMD_DEL_CHARS    = 4'd9
  } cmd_t;

  // Meaning of a byte in plain text
  typedef enum logic [2:0] {
    PK_OTHER,
    PK_ESC,
    PK_LF,
    PK_CR,
    PK_TAB,
    PK_BS,
    PK_BEL
  } plain_kind_t;

  // Meaning of a byte inside a control sequence
  typedef enum logic [3:0] {
    CK_OTHER,
    CK_DIGIT,
    CK_SEMI,
    CK_CUP,
    CK_UP,
    CK_DOWN,
    CK_RIGHT,
    CK_LEFT,
    CK_ED,
    CK_EL,
    CK_IL,
    CK_DL,
    CK_ICH,
    CK_DCH
  } csi_kind_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0]  code;
    plain_kind_t pkind;
    logic        printable;
    csi_kind_t   ckind;
    logic        is_lbr;
  } item_t;

endpackage

### hw/rtl/ansi_escape_cursor_parser_top.sv
// ----------------------------------------------------------------------------
// ansi_escape_cursor_parser_top
// Terminal byte parser with cursor tracking, one display command per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one terminal byte per request in in_tdata[7:0].
//   Output stream out_*: one display command per input byte, in order.
//   out_tuser carries the command code, out_tdata the glyph, the cursor
//   row and column after the byte and the insert/delete count.
// Path: a byte accepted on the input is written into the queue, then loaded
//   into the result register when the back end pops it, and shows on
//   out_tvalid from then on.
// Throughput: one byte per cycle while out_tready is high; the parser state
//   update in the back end is one register load from next-state logic, so
//   the loop through phase, arguments and cursor sets that rate.
// Stall: while the receiver holds out_tready low, the result stays put and
//   bytes go on filling the queue of QUEUE_DEPTH entries between front and
//   back; in_tready drops only when that queue is full.
// Reset: synchronous, active low. Queue empties, the parser returns to
//   plain text, the cursor goes to the bottom row, column zero, and both
//   arguments clear. No clearing pass; ready from the first cycle after.
// ----------------------------------------------------------------------------
module ansi_escape_cursor_parser_top
  import aecp_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] glyph, [12:8] row, [20:13] column,
                                  // [36:21] count, [39:37] zero
  output logic [3:0]  out_tuser   // [3:0] command
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t push_item, pop_item;

  // Front: accept and classify
  aecp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decoupling queue
  aecp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  // Back: parse, track cursor, hold result
  aecp_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/aecp_front.sv
// ----------------------------------------------------------------------------
// aecp_front
// Input side: takes bytes from the stream and classifies them for the back.
// ----------------------------------------------------------------------------
module aecp_front
  import aecp_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [7:0]  c;
  plain_kind_t pkind;
  csi_kind_t   ckind;

  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Plain-text class
  always_comb begin
    case (c)
      CH_ESC:  pkind = PK_ESC;
      CH_LF:   pkind = PK_LF;
      CH_CR:   pkind = PK_CR;
      CH_TAB:  pkind = PK_TAB;
      CH_BS:   pkind = PK_BS;
      CH_BEL:  pkind = PK_BEL;
      default: pkind = PK_OTHER;
    endcase
  end

  // Control-sequence class
  always_comb begin
    case (c)
      CH_SEMI:  ckind = CK_SEMI;
      CH_CUP:   ckind = CK_CUP;
      CH_UP:    ckind = CK_UP;
      CH_DOWN:  ckind = CK_DOWN;
      CH_RIGHT: ckind = CK_RIGHT;
      CH_LEFT:  ckind = CK_LEFT;
      CH_ED:    ckind = CK_ED;
      CH_EL:    ckind = CK_EL;
      CH_IL:    ckind = CK_IL;
      CH_DL:    ckind = CK_DL;
      CH_ICH:   ckind = CK_ICH;
      CH_DCH:   ckind = CK_DCH;
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) ckind = CK_DIGIT;
        else                              ckind = CK_OTHER;
      end
    endcase
  end

  // Classified request; graphic range is space up to DEL, and NBSP upwards
  always_comb begin
    q_item.code      = c;
    q_item.pkind     = pkind;
    q_item.printable = (c >= CH_SPACE) && ((c <= CH_DEL) || (c >= CH_NBSP));
    q_item.ckind     = ckind;
    q_item.is_lbr    = (c == CH_LBR);
  end

endmodule

### hw/rtl/aecp_queue.sv
// ----------------------------------------------------------------------------
// aecp_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module aecp_queue
  import aecp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/aecp_back.sv
// ----------------------------------------------------------------------------
// aecp_back
// Execution side: parse phase, arguments, cursor and the output register.
// ----------------------------------------------------------------------------
module aecp_back
  import aecp_pkg::*;
#(
  parameter int ROWS = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [3:0]  out_tuser
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_ESC,
    PH_CSI
  } phase_t;

  phase_t           phase_r,  phase_nxt;
  logic [ROW_W-1:0] row_r,    row_nxt;
  logic [7:0]       col_r,    col_nxt;
  logic [1:0]       idx_r,    idx_nxt;
  logic [15:0]      arg0_r,   arg0_nxt;
  logic [15:0]      arg1_r,   arg1_nxt;
  logic             out_valid_r;
  cmd_t             cmd_r,    cmd_nxt;
  logic [7:0]       glyph_r,  glyph_nxt;
  logic [4:0]       orow_r;
  logic [15:0]      cnt_r,    cnt_nxt;

  // Arithmetic helpers
  logic [15:0]      amt;
  logic [15:0]      arg_cur;
  logic [19:0]      acc;
  logic [15:0]      acc_sat;
  logic [15:0]      row_ext;
  logic [15:0]      down_room;
  logic [15:0]      cup_row;
  logic [15:0]      arg1_m1;
  logic [7:0]       cup_col;
  logic [16:0]      right_sum;
  logic [7:0]       right_col;
  logic [9:0]       tab_sum;
  logic [7:0]       tab_col;
  logic [7:0]       inc_col;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W+4:0] row_out_ext;
  logic             do_plain;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // Decimal argument accumulation: a*10 + digit, saturating
  assign arg_cur = idx_r[0] ? arg1_r : arg0_r;
  assign acc     = ({4'b0, arg_cur} << 3) + ({4'b0, arg_cur} << 1)
                 + {16'b0, q_item.code[3:0]};
  assign acc_sat = (acc[19:16] != 4'b0) ? 16'hFFFF : acc[15:0];

  // Cursor arithmetic
  assign amt       = (arg0_r != 16'd0) ? arg0_r : 16'd1;
  assign row_ext   = {{(16 - ROW_W){1'b0}}, row_r};
  assign down_room = 16'(ROWS - 1) - row_ext;
  assign cup_row   = (arg0_r != 16'd0) ? arg0_r - 16'd1 : 16'd0;
  assign arg1_m1   = arg1_r - 16'd1;
  assign cup_col   = (arg1_r == 16'd0) ? 8'd0 :
                     (arg1_m1 > 16'd255) ? 8'hFF : arg1_m1[7:0];
  assign right_sum = {9'b0, col_r} + {1'b0, amt};
  assign right_col = (right_sum > 17'd255) ? 8'hFF : right_sum[7:0];
  assign tab_sum   = (10'(col_r) / 10'(TAB_WIDTH) + 10'd1) * 10'(TAB_WIDTH);
  assign tab_col   = (tab_sum > 10'd255) ? 8'hFF : tab_sum[7:0];
  assign inc_col   = (col_r == 8'hFF) ? 8'hFF : col_r + 8'd1;
  assign row_inc   = {1'b0, row_r} + 1'b1;

  // Next state and result for the item at the head of the queue
  always_comb begin
    phase_nxt = PH_PLAIN;
    row_nxt   = row_r;
    col_nxt   = col_r;
    idx_nxt   = idx_r;
    arg0_nxt  = arg0_r;
    arg1_nxt  = arg1_r;
    cmd_nxt   = CMD_NONE;
    glyph_nxt = 8'd0;
    cnt_nxt   = 16'd1;
    do_plain  = 1'b0;

    case (phase_r)
      PH_ESC: begin
        if (q_item.is_lbr) begin
          arg0_nxt  = 16'd0;
          arg1_nxt  = 16'd0;
          idx_nxt   = 2'd0;
          phase_nxt = PH_CSI;
        end else begin
          do_plain = 1'b1;
        end
      end
      PH_CSI: begin
        case (q_item.ckind)
          CK_DIGIT: begin
            if (idx_r < 2'd2) begin
              if (idx_r[0]) arg1_nxt = acc_sat;
              else          arg0_nxt = acc_sat;
              phase_nxt = PH_CSI;
            end else begin
              do_plain = 1'b1;
            end
          end
          CK_SEMI: begin
            if (idx_r < 2'd2) idx_nxt = idx_r + 2'd1;
            phase_nxt = PH_CSI;
          end
          CK_CUP: begin
            col_nxt = cup_col;
            if (cup_row < 16'(ROWS)) row_nxt = cup_row[ROW_W-1:0];
          end
          CK_UP: begin
            if (amt <= row_ext) row_nxt = row_r - amt[ROW_W-1:0];
          end
          CK_DOWN: begin
            if (amt <= down_room) row_nxt = row_r + amt[ROW_W-1:0];
          end
          CK_LEFT: begin
            if (amt <= {8'b0, col_r}) col_nxt = col_r - amt[7:0];
          end
          CK_RIGHT: col_nxt = right_col;
          CK_ED: begin
            row_nxt = '0;
            col_nxt = 8'd0;
            cmd_nxt = CMD_ERASE_SCREEN;
          end
          CK_IL: begin
            col_nxt = 8'd0;
            cmd_nxt = CMD_INS_LINE;
          end
          CK_DL: begin
            col_nxt = 8'd0;
            cmd_nxt = CMD_DEL_LINE;
          end
          CK_EL: cmd_nxt = CMD_ERASE_EOL;
          CK_ICH: begin
            cmd_nxt = CMD_INS_CHARS;
            cnt_nxt = amt;
          end
          CK_DCH: begin
            cmd_nxt = CMD_DEL_CHARS;
            cnt_nxt = amt;
          end
          default: do_plain = 1'b1;
        endcase
      end
      default: do_plain = 1'b1;
    endcase

    // Plain-text handling, also for bytes that end a sequence
    if (do_plain) begin
      case (q_item.pkind)
        PK_ESC: phase_nxt = PH_ESC;
        PK_LF: begin
          if (row_inc >= (ROW_W + 1)'(ROWS)) begin
            row_nxt = ROW_W'(ROWS - 1);
            cmd_nxt = CMD_SCROLL;
          end else begin
            row_nxt = row_inc[ROW_W-1:0];
          end
          col_nxt = 8'd0;
        end
        PK_CR:  col_nxt = 8'd0;
        PK_TAB: col_nxt = tab_col;
        PK_BS: begin
          if (col_r != 8'd0) col_nxt = col_r - 8'd1;
        end
        PK_BEL: cmd_nxt = CMD_BELL;
        default: begin
          if (q_item.printable && (col_r < 8'(COLUMNS))) begin
            cmd_nxt   = CMD_PLOT;
            glyph_nxt = q_item.code;
          end
          col_nxt = inc_col;
        end
      endcase
    end
  end

  assign row_out_ext = {5'b0, row_nxt};

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PLAIN;
      row_r       <= ROW_W'(ROWS - 1);
      col_r       <= 8'd0;
      idx_r       <= 2'd0;
      arg0_r      <= 16'd0;
      arg1_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        idx_r       <= idx_nxt;
        arg0_r      <= arg0_nxt;
        arg1_r      <= arg1_nxt;
        out_valid_r <= 1'b1;
        cmd_r       <= cmd_nxt;
        glyph_r     <= glyph_nxt;
        orow_r      <= row_out_ext[4:0];
        cnt_r       <= cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = cmd_r;
  assign out_tdata  = {3'b000, cnt_r, col_r, orow_r, glyph_r};

endmodule

### hw/rtl/aecp_checker.sv
// ----------------------------------------------------------------------------
// aecp_checker
// Port-level checks on the parser top, attached by bind.
// ----------------------------------------------------------------------------
module aecp_checker
  import aecp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // Nothing left over in the result register after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Glyph is set for plot only, and then is no lower than space
  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == CMD_PLOT) ? (out_tdata[7:0] >= CH_SPACE)
                                           : (out_tdata[7:0] == 8'd0))
    else $error("glyph does not match command");

  // Count differs from one only for character insert and delete
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != CMD_INS_CHARS) && (out_tuser != CMD_DEL_CHARS)
      |-> out_tdata[36:21] == 16'd1)
    else $error("count set on a command without count");

  // Count is never zero and padding stays clear
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:21] != 16'd0) && (out_tdata[39:37] == 3'd0))
    else $error("zero count or padding set");

endmodule

bind ansi_escape_cursor_parser_top aecp_checker u_aecp_checker (.*);
